FILE: rtl/apl_pkg.sv
// ----------------------------------------------------------------------------
// apl_pkg
// Shared types and constants of the anchor piecewise-linear map.
// ----------------------------------------------------------------------------
package apl_pkg;

  localparam int APL_MAX_ANCHORS = 64;
  localparam int APL_LINE_W      = 31;
  localparam int APL_MAP_W       = 33;

  typedef enum logic [2:0] {
    F_ADD    = 3'd0,
    F_REMOVE = 3'd1,
    F_CLEAR  = 3'd2,
    F_MAP_AB = 3'd3,
    F_MAP_BA = 3'd4,
    F_SWAP   = 3'd5,
    F_READ   = 3'd6,
    F_NOP    = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_IDX  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [APL_LINE_W-1:0] a;
    logic [APL_LINE_W-1:0] b;
  } ent_t;

endpackage

FILE: rtl/apl_ram.sv
// ----------------------------------------------------------------------------
// apl_ram
// Generic single-write, single-read memory with a registered read.
// ----------------------------------------------------------------------------
module apl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/apl_div.sv
// ----------------------------------------------------------------------------
// apl_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module apl_div #(
  parameter int NUM_W = 62,
  parameter int DEN_W = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W:0]   trial;
  logic             fit;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fit   = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_W);
        rem_r  <= '0;
        den_r  <= den;
        quo_r  <= num;
      end else if (busy_r) begin
        rem_r <= fit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], fit};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: rtl/anchor_piecewise_linear_map.sv
// ----------------------------------------------------------------------------
// anchor_piecewise_linear_map
// Sorted table of anchor pairs with piecewise-linear mapping between panes.
// ----------------------------------------------------------------------------
// One request is handled at a time, each by a walk over the single anchor memory.
// Clear, no-op and rejected requests go straight to the result; read entry reads
// one slot, remove shifts the entries after the index down, add shifts entries up
// from the end until the new pair's place, a map query scans every anchor and,
// when the value lies between the anchors, then runs the divider, and swap panes
// exchanges the two lines of each entry and then re-sorts with an insertion sort.
module anchor_piecewise_linear_map
  import apl_pkg::*;
#(
  parameter int MAX_ANCHORS = APL_MAX_ANCHORS,
  localparam int AW    = $clog2(MAX_ANCHORS),
  localparam int CNT_W = $clog2(MAX_ANCHORS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_func,
  input  logic [APL_LINE_W-1:0] in_line_a,
  input  logic [APL_LINE_W-1:0] in_line_b,
  input  logic [5:0]            in_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [APL_MAP_W-1:0]  out_mapped_line,
  output logic [APL_LINE_W-1:0] out_entry_line_a,
  output logic [APL_LINE_W-1:0] out_entry_line_b,
  output logic [CNT_W-1:0]      out_anchor_count
);

  localparam int IXW = CNT_W + 6;

  typedef enum logic [4:0] {
    S_IDLE, S_SH_RD, S_SH_CMP, S_RM_RD, S_RM_WR, S_RE_RD, S_RE_CAP,
    S_Q_RD, S_Q_CMP, S_Q_FIN, S_Q_DST, S_Q_DIV, S_SW_RD, S_SW_WR,
    S_SO_RD, S_SO_KEY, S_OUT
  } state_t;

  state_t                state_r;
  func_t                 func_r;
  logic [APL_LINE_W-1:0] la_r, lb_r;
  logic [IXW-1:0]        idx_r;
  logic [CNT_W-1:0]      count_r, i_r, j_r;
  ent_t                  key_r;
  logic                  strict_r, sorting_r;
  logic [APL_LINE_W-1:0] first_s_r, first_d_r, last_s_r, last_d_r;
  logic [APL_LINE_W-1:0] lo_s_r, lo_d_r, hi_s_r, hi_d_r;
  logic                  lo_v_r, hi_v_r;
  logic signed [63:0]    prod_r;
  logic [1:0]            status_r;
  logic [APL_MAP_W-1:0]  mapped_r;
  logic [APL_LINE_W-1:0] ea_r, eb_r;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  ent_t                  ram_wdata, rd;
  logic                  move;
  logic [APL_LINE_W-1:0] v, s, d;
  logic [IXW-1:0]        in_idx_ext;
  logic [CNT_W-1:0]      i_inc, j_dec;
  logic                  div_start, div_done;
  logic [61:0]           div_num, div_quo;
  logic [APL_LINE_W-1:0] div_den;
  logic signed [63:0]    prod_full;
  logic signed [APL_MAP_W-1:0] end_first, end_last, q_signed;

  apl_ram #(.WIDTH($bits(ent_t)), .DEPTH(MAX_ANCHORS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  apl_div #(.NUM_W(62), .DEN_W(APL_LINE_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_idx_ext = {{CNT_W{1'b0}}, in_index};
  assign i_inc      = i_r + 1'b1;
  assign j_dec      = j_r - 1'b1;
  assign move       = strict_r ? (rd.a > key_r.a) : (rd.a >= key_r.a);
  assign v          = (func_r == F_MAP_AB) ? la_r : lb_r;
  assign s          = (func_r == F_MAP_AB) ? rd.a : rd.b;
  assign d          = (func_r == F_MAP_AB) ? rd.b : rd.a;

  assign end_first = $signed({2'b00, v}) + $signed({2'b00, first_d_r})
                   - $signed({2'b00, first_s_r});
  assign end_last  = $signed({2'b00, v}) + $signed({2'b00, last_d_r})
                   - $signed({2'b00, last_s_r});
  assign prod_full = $signed({1'b0, APL_LINE_W'(v - lo_s_r)})
                   * ($signed({1'b0, hi_d_r}) - $signed({1'b0, lo_d_r}));

  assign div_start = (state_r == S_Q_DST);
  assign div_num   = prod_r[63] ? 62'(-prod_r) : prod_r[61:0];
  assign div_den   = hi_s_r - lo_s_r;
  assign q_signed  = prod_r[63] ? -$signed({1'b0, div_quo[31:0]})
                                :  $signed({1'b0, div_quo[31:0]});

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = j_r[AW-1:0];
    ram_wdata = key_r;
    ram_raddr = i_r[AW-1:0];
    unique case (state_r)
      S_SH_RD: begin
        ram_raddr = j_dec[AW-1:0];
        if (j_r == '0) begin
          ram_we = 1'b1;
        end
      end
      S_SH_CMP: begin
        ram_we = 1'b1;
        if (move) begin
          ram_wdata = rd;
        end
      end
      S_RM_RD: ram_raddr = i_inc[AW-1:0];
      S_RM_WR: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[AW-1:0];
        ram_wdata = rd;
      end
      S_RE_RD: ram_raddr = idx_r[AW-1:0];
      S_SW_WR: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[AW-1:0];
        ram_wdata = '{a: rd.b, b: rd.a};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            func_r   <= func_t'(in_func);
            la_r     <= in_line_a;
            lb_r     <= in_line_b;
            idx_r    <= in_idx_ext;
            status_r <= ST_OK;
            mapped_r <= '0;
            ea_r     <= '0;
            eb_r     <= '0;
            i_r      <= '0;
            lo_v_r   <= 1'b0;
            hi_v_r   <= 1'b0;
            unique case (func_t'(in_func))
              F_ADD: begin
                if (count_r == CNT_W'(MAX_ANCHORS)) begin
                  status_r <= ST_FULL;
                  state_r  <= S_OUT;
                end else begin
                  key_r     <= '{a: in_line_a, b: in_line_b};
                  j_r       <= count_r;
                  strict_r  <= 1'b0;
                  sorting_r <= 1'b0;
                  state_r   <= S_SH_RD;
                end
              end
              F_REMOVE, F_READ: begin
                if (in_idx_ext >= {6'b0, count_r}) begin
                  status_r <= ST_IDX;
                  state_r  <= S_OUT;
                end else begin
                  i_r     <= in_idx_ext[CNT_W-1:0];
                  state_r <= (func_t'(in_func) == F_READ) ? S_RE_RD : S_RM_RD;
                end
              end
              F_CLEAR: begin
                count_r <= '0;
                state_r <= S_OUT;
              end
              F_MAP_AB, F_MAP_BA: state_r <= S_Q_RD;
              F_SWAP:             state_r <= S_SW_RD;
              F_NOP:              state_r <= S_OUT;
            endcase
          end
        end
        S_SH_RD: begin
          if (j_r == '0) begin
            if (sorting_r) begin
              i_r     <= i_inc;
              state_r <= S_SO_RD;
            end else begin
              count_r <= count_r + 1'b1;
              state_r <= S_OUT;
            end
          end else begin
            state_r <= S_SH_CMP;
          end
        end
        S_SH_CMP: begin
          if (move) begin
            j_r     <= j_dec;
            state_r <= S_SH_RD;
          end else if (sorting_r) begin
            i_r     <= i_inc;
            state_r <= S_SO_RD;
          end else begin
            count_r <= count_r + 1'b1;
            state_r <= S_OUT;
          end
        end
        S_RM_RD: begin
          if (i_inc < count_r) begin
            state_r <= S_RM_WR;
          end else begin
            count_r <= count_r - 1'b1;
            state_r <= S_OUT;
          end
        end
        S_RM_WR: begin
          i_r     <= i_inc;
          state_r <= S_RM_RD;
        end
        S_RE_RD: state_r <= S_RE_CAP;
        S_RE_CAP: begin
          ea_r    <= rd.a;
          eb_r    <= rd.b;
          state_r <= S_OUT;
        end
        S_Q_RD: state_r <= (i_r == count_r) ? S_Q_FIN : S_Q_CMP;
        S_Q_CMP: begin
          if (i_r == '0 || s < first_s_r) begin
            first_s_r <= s;
            first_d_r <= d;
          end
          if (i_r == '0 || s >= last_s_r) begin
            last_s_r <= s;
            last_d_r <= d;
          end
          if (s < v && (!lo_v_r || s >= lo_s_r)) begin
            lo_s_r <= s;
            lo_d_r <= d;
            lo_v_r <= 1'b1;
          end
          if (s >= v && (!hi_v_r || s < hi_s_r)) begin
            hi_s_r <= s;
            hi_d_r <= d;
            hi_v_r <= 1'b1;
          end
          i_r     <= i_inc;
          state_r <= S_Q_RD;
        end
        S_Q_FIN: begin
          priority if (count_r == '0) begin
            mapped_r <= {2'b00, v};
            state_r  <= S_OUT;
          end else if (v <= first_s_r) begin
            mapped_r <= end_first;
            state_r  <= S_OUT;
          end else if (v >= last_s_r) begin
            mapped_r <= end_last;
            state_r  <= S_OUT;
          end else begin
            prod_r  <= prod_full;
            state_r <= S_Q_DST;
          end
        end
        S_Q_DST: state_r <= S_Q_DIV;
        S_Q_DIV: begin
          if (div_done) begin
            mapped_r <= $signed({2'b00, lo_d_r}) + q_signed;
            state_r  <= S_OUT;
          end
        end
        S_SW_RD: begin
          if (i_r == count_r) begin
            i_r       <= CNT_W'(1);
            sorting_r <= 1'b1;
            strict_r  <= 1'b1;
            state_r   <= S_SO_RD;
          end else begin
            state_r <= S_SW_WR;
          end
        end
        S_SW_WR: begin
          i_r     <= i_inc;
          state_r <= S_SW_RD;
        end
        S_SO_RD: state_r <= (i_r >= count_r) ? S_OUT : S_SO_KEY;
        S_SO_KEY: begin
          key_r   <= rd;
          j_r     <= i_r;
          state_r <= S_SH_RD;
        end
        S_OUT: begin
          if (!out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_OUT);
  assign out_status       = status_r;
  assign out_mapped_line  = mapped_r;
  assign out_entry_line_a = ea_r;
  assign out_entry_line_b = eb_r;
  assign out_anchor_count = count_r;

  a_no_input_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request accepted while a result is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ANCHORS))
    else $error("anchor count above capacity");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_Q_DIV)
    else $error("divider finished outside the wait state");

  a_count_stable_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Q_CMP) |=> $stable(count_r))
    else $error("anchor count changed during a query");

endmodule
